// ----- design/rhh_pkg.sv -----
// Shared constants, status codes and slot record types for the hash table unit.
`timescale 1ns / 1ps
package rhh_pkg;
   localparam int unsigned SLOTS  = 1024;
   localparam int          IDX_W  = $clog2(SLOTS);
   localparam int          CNT_W  = $clog2(SLOTS + 1);
   localparam int          DIST_W = CNT_W;

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
   localparam logic [10:0]      MAX_RECORDS_RESET = 11'd798;

   localparam logic [2:0] ST_UPDATED   = 3'd0;
   localparam logic [2:0] ST_INSERTED  = 3'd1;
   localparam logic [2:0] ST_FOUND     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_M1     = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_M2     = 64'h94d049bb133111eb;

   typedef struct packed {
      logic              valid;
      logic [DIST_W-1:0] disp;
      logic [63:0]       fp;
      logic [63:0]       key;
      logic [63:0]       val;
   } slot_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      slot_type         wdata;
      logic [IDX_W-1:0] raddr;
   } ram_cmd_type;
endpackage

// ----- design/rhh_if.sv -----
// Channel interfaces for requests, responses and the configuration write port.
`timescale 1ns / 1ps
interface rhh_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [63:0] fingerprint;
   logic [63:0] key_word;
   logic [63:0] value_word;
   modport source (output valid, mode, fingerprint, key_word, value_word, input ready);
   modport sink (input valid, mode, fingerprint, key_word, value_word, output ready);
endinterface

interface rhh_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [63:0] found_value;
   logic [10:0] occupancy;
   modport source (output valid, status, found_value, occupancy, input ready);
   modport sink (input valid, status, found_value, occupancy, output ready);
endinterface

interface rhh_csr_if;
   logic        valid;
   logic        ready;
   logic [10:0] write_data;
   modport source (output valid, write_data, input ready);
   modport sink (input valid, write_data, output ready);
endinterface

// ----- design/rhh_hash.sv -----
// Multi-cycle mix64 finalizer and home slot reduction modulo the slot count.
`timescale 1ns / 1ps
module rhh_hash (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [63:0]               fingerprint,
   output logic                      done,
   output logic [rhh_pkg::IDX_W-1:0] home
);
   import rhh_pkg::*;

   localparam logic [2:0] H_IDLE = 3'd0;
   localparam logic [2:0] H_XS   = 3'd1;
   localparam logic [2:0] H_MUL  = 3'd2;
   localparam logic [2:0] H_FIN  = 3'd3;
   localparam logic [2:0] H_MOD  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [63:0]      x_ff, x_in;
   logic [63:0]      a_ff, a_in;
   logic [63:0]      acc_ff, acc_in;
   logic             pass_ff, pass_in;
   logic [1:0]       step_ff, step_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic             done_ff, done_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_c, prod;
   logic [IDX_W:0] r;

   always_comb begin
      mul_c = pass_ff ? MIX_M2 : MIX_M1;
      case (step_ff)
         2'd0: begin
            mul_a = a_ff[31:0];
            mul_b = mul_c[31:0];
         end
         2'd1: begin
            mul_a = a_ff[63:32];
            mul_b = mul_c[31:0];
         end
         default: begin
            mul_a = a_ff[31:0];
            mul_b = mul_c[63:32];
         end
      endcase
      prod = {32'd0, mul_a} * {32'd0, mul_b};
   end

   always_comb begin
      r = {1'b0, rem_ff};
      for (int i = 7; i >= 0; i--) begin
         r = {r[IDX_W-1:0], x_ff[56+i]};
         if (r >= (IDX_W+1)'(SLOTS)) r = r - (IDX_W+1)'(SLOTS);
      end
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      a_in     = a_ff;
      acc_in   = acc_ff;
      pass_in  = pass_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               x_in     = fingerprint + MIX_GOLDEN;
               pass_in  = 1'b0;
               state_in = H_XS;
            end
         end
         H_XS: begin
            a_in     = pass_ff ? (x_ff ^ (x_ff >> 27)) : (x_ff ^ (x_ff >> 30));
            step_in  = 2'd0;
            state_in = H_MUL;
         end
         H_MUL: begin
            case (step_ff)
               2'd0: begin
                  acc_in  = prod;
                  step_in = 2'd1;
               end
               2'd1: begin
                  acc_in  = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
                  step_in = 2'd2;
               end
               default: begin
                  x_in = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
                  if (!pass_ff) begin
                     pass_in  = 1'b1;
                     state_in = H_XS;
                  end else begin
                     state_in = H_FIN;
                  end
               end
            endcase
         end
         H_FIN: begin
            x_in     = x_ff ^ (x_ff >> 31);
            rem_in   = '0;
            cnt_in   = 3'd0;
            state_in = H_MOD;
         end
         H_MOD: begin
            rem_in = r[IDX_W-1:0];
            x_in   = x_ff << 8;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               done_in  = 1'b1;
               state_in = H_IDLE;
            end
         end
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff    <= x_in;
      a_ff    <= a_in;
      acc_ff  <= acc_in;
      pass_ff <= pass_in;
      step_ff <= step_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign home = rem_ff;
endmodule

// ----- design/rhh_slot_ram.sv -----
// Slot record memory: one write port, one registered read port.
`timescale 1ns / 1ps
module rhh_slot_ram (
   input  logic                 clock,
   input  rhh_pkg::ram_cmd_type cmd,
   output rhh_pkg::slot_type    rd_data
);
   import rhh_pkg::*;

   slot_type mem [SLOTS];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) mem[cmd.waddr] <= cmd.wdata;
      rd_data_ff <= mem[cmd.raddr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- design/robin_hood_hash_table_unit.sv -----
// Top level: Robin Hood hash table partition with probe sequencer.
//
//   channel    direction  contents
//   req_chan   in         mode, fingerprint, key_word, value_word
//   rsp_chan   out        status, found_value, occupancy
//   csr_chan   in         write_data (max_records)
//
// A transaction is accepted in idle and hashed, then takes a memory read and a
// check/write per probed slot, then loads the response register.
// After reset a clearing pass writes all SLOTS (1024) slots before the first
// request is taken; csr writes are taken at any time.
// A response waits in its register while the next request is taken and hashed.
`timescale 1ns / 1ps
module robin_hood_hash_table_unit (
   input logic        clock,
   input logic        reset,
   rhh_req_if.sink    req_chan,
   rhh_rsp_if.source  rsp_chan,
   rhh_csr_if.sink    csr_chan
);
   import rhh_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [10:0]       max_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              mode_ff, mode_in;
   logic [63:0]       fp_ff, fp_in;
   logic [63:0]       key_ff, key_in;
   logic [63:0]       val_ff, val_in;
   logic [DIST_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              ins_ff, ins_in;
   logic [2:0]        status_ff, status_in;
   logic [63:0]       found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [63:0]       rsp_found_ff, rsp_found_in;
   logic [10:0]       rsp_occ_ff, rsp_occ_in;

   logic              accept;
   logic              hash_done;
   logic [IDX_W-1:0]  home;
   ram_cmd_type       cmd;
   slot_type          e;
   logic              stop, match, last, full;
   logic [IDX_W-1:0]  idx_nx;

   assign accept = req_chan.valid && req_chan.ready;

   rhh_hash u_hash (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .fingerprint (req_chan.fingerprint),
      .done        (hash_done),
      .home        (home)
   );

   rhh_slot_ram u_ram (
      .clock   (clock),
      .cmd     (cmd),
      .rd_data (e)
   );

   always_comb begin
      stop   = !e.valid || (e.disp < d_ff);
      match  = (e.fp == fp_ff) && (e.key == key_ff);
      last   = (n_ff == SLOTS_CNT - CNT_W'(1));
      idx_nx = (idx_ff == LAST_SLOT) ? '0 : idx_ff + IDX_W'(1);
      full   = (32'(count_ff) >= 32'(max_ff)) || (count_ff >= SLOTS_CNT);
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      mode_in       = mode_ff;
      fp_in         = fp_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      d_in          = d_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      ins_in        = ins_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_occ_in    = rsp_occ_ff;
      cmd.we        = 1'b0;
      cmd.waddr     = idx_ff;
      cmd.wdata     = '{valid: 1'b1, disp: d_ff, fp: fp_ff, key: key_ff, val: val_ff};
      cmd.raddr     = idx_ff;

      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            cmd.we    = 1'b1;
            cmd.waddr = clr_ff;
            cmd.wdata = '0;
            clr_in    = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_SLOT) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               mode_in  = req_chan.mode;
               fp_in    = req_chan.fingerprint;
               key_in   = req_chan.key_word;
               val_in   = req_chan.value_word;
               found_in = '0;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               idx_in   = home;
               d_in     = '0;
               n_in     = '0;
               ins_in   = 1'b0;
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            if (!ins_ff) begin
               if (stop || (!match && last)) begin
                  if (!mode_ff) begin
                     status_in = ST_NOT_FOUND;
                     state_in  = S_DONE;
                  end else if (full) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     ins_in   = 1'b1;
                     n_in     = '0;
                     state_in = S_READ;
                     if (!stop) begin
                        idx_in = idx_nx;
                        d_in   = d_ff + DIST_W'(1);
                     end
                  end
               end else if (match) begin
                  if (mode_ff) begin
                     cmd.we     = 1'b1;
                     cmd.wdata  = e;
                     cmd.wdata.val = val_ff;
                     status_in  = ST_UPDATED;
                  end else begin
                     status_in = ST_FOUND;
                     found_in  = e.val;
                  end
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_nx;
                  d_in     = d_ff + DIST_W'(1);
                  n_in     = n_ff + CNT_W'(1);
                  state_in = S_READ;
               end
            end else begin
               if (!e.valid) begin
                  cmd.we    = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
                  status_in = ST_INSERTED;
                  state_in  = S_DONE;
               end else begin
                  if (e.disp < d_ff) begin
                     cmd.we = 1'b1;
                     fp_in  = e.fp;
                     key_in = e.key;
                     val_in = e.val;
                     d_in   = e.disp + DIST_W'(1);
                  end else begin
                     d_in = d_ff + DIST_W'(1);
                  end
                  idx_in = idx_nx;
                  n_in   = n_ff + CNT_W'(1);
                  if (last) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_occ_in    = 11'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         max_ff       <= MAX_RECORDS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) max_ff <= csr_chan.write_data;
      end
      mode_ff       <= mode_in;
      fp_ff         <= fp_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      d_ff          <= d_in;
      n_ff          <= n_in;
      idx_ff        <= idx_in;
      ins_ff        <= ins_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found_value = rsp_found_ff;
   assign rsp_chan.occupancy   = rsp_occ_ff;
endmodule

// ----- verif/tb_robin_hood_hash_table_unit.sv -----
// Self-checking testbench for the Robin Hood hash table unit with scoreboard predictor.
`timescale 1ns / 1ps
module tb_robin_hood_hash_table_unit;
   import rhh_pkg::*;

   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;
   localparam int   POOL_SIZE = 160;
   localparam int   HOLD_CYCLES = 3000;

   typedef struct {
      logic [2:0]  status;
      logic [63:0] value;
      logic [10:0] occ;
   } reply_type;

   function automatic logic [63:0] scramble(logic [63:0] x);
      logic [63:0] y;
      y = x + MIX_GOLDEN;
      y = (y ^ (y >> 30)) * MIX_M1;
      y = (y ^ (y >> 27)) * MIX_M2;
      return y ^ (y >> 31);
   endfunction

   function automatic int home_of(logic [63:0] fp);
      return int'(scramble(fp) % 64'(SLOTS));
   endfunction

   class table_scoreboard;
      logic [63:0] tab_fp[SLOTS];
      logic [63:0] tab_key[SLOTS];
      logic [63:0] tab_val[SLOTS];
      int          tab_dist[SLOTS];
      bit          tab_used[SLOTS];
      int          records;
      int          limit;
      reply_type   replies[$];
      int          errors;

      function new();
         foreach (tab_used[i]) tab_used[i] = 0;
         records = 0;
         limit = int'(MAX_RECORDS_RESET);
         errors = 0;
      endfunction

      function void note(logic mode, logic [63:0] fp, logic [63:0] key, logic [63:0] val);
         int idx, d, n, td;
         bit hit;
         logic [63:0] cf, ck, cv, tf, tk, tv;
         reply_type r;
         idx = home_of(fp);
         d = 0;
         hit = 0;
         r.value = '0;
         for (n = 0; n < SLOTS; n++) begin
            if (!tab_used[idx] || tab_dist[idx] < d) break;
            if (tab_fp[idx] == fp && tab_key[idx] == key) begin
               hit = 1;
               break;
            end
            idx = (idx + 1 >= SLOTS) ? 0 : idx + 1;
            d++;
         end
         if (mode == MODE_GET) begin
            r.status = hit ? ST_FOUND : ST_NOT_FOUND;
            if (hit) r.value = tab_val[idx];
         end else if (hit) begin
            tab_val[idx] = val;
            r.status = ST_UPDATED;
         end else if (records >= limit || records >= SLOTS) begin
            r.status = ST_FULL;
         end else begin
            cf = fp; ck = key; cv = val;
            r.status = ST_FULL;
            for (n = 0; n < SLOTS; n++) begin
               if (!tab_used[idx]) begin
                  tab_used[idx] = 1;
                  tab_fp[idx] = cf; tab_key[idx] = ck; tab_val[idx] = cv;
                  tab_dist[idx] = d;
                  records++;
                  r.status = ST_INSERTED;
                  break;
               end
               if (tab_dist[idx] < d) begin
                  tf = tab_fp[idx]; tk = tab_key[idx]; tv = tab_val[idx]; td = tab_dist[idx];
                  tab_fp[idx] = cf; tab_key[idx] = ck; tab_val[idx] = cv;
                  tab_dist[idx] = d;
                  cf = tf; ck = tk; cv = tv; d = td;
               end
               idx = (idx + 1 >= SLOTS) ? 0 : idx + 1;
               d++;
            end
         end
         r.occ = 11'(records);
         replies = {replies, r};
      endfunction

      function void check(logic [2:0] status, logic [63:0] value, logic [10:0] occ);
         reply_type r;
         if (replies.size() == 0) begin
            $error("unexpected response transaction: status %0d", status);
            errors++;
            return;
         end
         r = replies.pop_front();
         if (status !== r.status) begin
            $error("status: expected %0d actual %0d", r.status, status);
            errors++;
         end
         if (value !== r.value) begin
            $error("found_value: expected %h actual %h", r.value, value);
            errors++;
         end
         if (occ !== r.occ) begin
            $error("occupancy: expected %0d actual %0d", r.occ, occ);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   rhh_req_if req_bus ();
   rhh_rsp_if rsp_bus ();
   rhh_csr_if csr_bus ();

   robin_hood_hash_table_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   table_scoreboard sb;
   int send_idle;
   int recv_stall;
   int hold_asks;
   logic [63:0] pool_fp[POOL_SIZE];
   logic [63:0] pool_key[POOL_SIZE];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int hold_seen, hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check(rsp_bus.status, rsp_bus.found_value, rsp_bus.occupancy);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send(logic mode, logic [63:0] fp, logic [63:0] key, logic [63:0] val);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= mode;
      req_bus.fingerprint <= fp;
      req_bus.key_word <= key;
      req_bus.value_word <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note(mode, fp, key, val);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(logic [10:0] limit);
      csr_bus.valid <= 1'b1;
      csr_bus.write_data <= limit;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      sb.limit = int'(limit);
      @(posedge clock);
   endtask

   initial begin
      logic [63:0] ones;
      logic [63:0] fp;
      int i, p, j, pick;
      int idle_send[4];
      int idle_recv[4];
      logic [10:0] limits[4];
      ones = '1;
      idle_send = '{0, 84, 0, 29};
      idle_recv = '{0, 0, 84, 29};
      limits = '{11'd1024, 11'd60, 11'd1023, 11'd798};
      sb = new();
      send_idle = 0;
      recv_stall = 0;
      hold_asks = 0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.mode <= MODE_GET;
      req_bus.fingerprint <= '0;
      req_bus.key_word <= '0;
      req_bus.value_word <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.write_data <= '0;

      for (i = 0; i < POOL_SIZE; i++) begin
         if (i % 5 == 4) begin
            fp = pool_fp[i-1];
         end else if (i % 2 == 0) begin
            fp = rand64();
            while (((home_of(fp) + 16) % SLOTS) >= 64) fp = rand64();
         end else begin
            fp = rand64();
         end
         pool_fp[i] = fp;
         pool_key[i] = rand64();
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(MODE_GET, '0, '0, ones);
      send(MODE_PUT, '0, '0, '0);
      send(MODE_PUT, ones, ones, ones);
      send(MODE_GET, '0, '0, '0);
      send(MODE_GET, ones, ones, '0);
      send(MODE_PUT, '0, '0, 64'h5a5a_a5a5_0f0f_f0f0);
      send(MODE_GET, '0, ones, '0);
      send(MODE_PUT, '0, ones, 64'h1234_5678_9abc_def0);
      send(MODE_GET, '0, ones, '0);
      send(MODE_GET, '0, '0, '0);
      for (i = 0; i < 6; i++) send(MODE_PUT, pool_fp[i], pool_key[i], rand64());
      for (i = 0; i < 6; i++) send(MODE_GET, pool_fp[i], pool_key[i], rand64());
      drain();
      write_limit(11'd3);
      send(MODE_PUT, rand64(), rand64(), rand64());
      send(MODE_PUT, '0, '0, ones);
      send(MODE_GET, '0, '0, '0);
      drain();
      write_limit(11'd0);
      send(MODE_PUT, rand64(), rand64(), rand64());
      drain();

      for (p = 0; p < 4; p++) begin
         write_limit(limits[p]);
         send_idle = idle_send[p];
         recv_stall = idle_recv[p];
         for (j = 0; j < 125; j++) begin
            if (p == 0 && j == 20) hold_asks++;
            if ($urandom_range(99) < 80) begin
               pick = $urandom_range(POOL_SIZE - 1);
               send(1'($urandom_range(1)), pool_fp[pick], pool_key[pick], rand64());
            end else begin
               send(1'($urandom_range(1)), rand64(), rand64(), rand64());
            end
         end
         drain();
      end

      send_idle = 0;
      recv_stall = 0;
      drain();
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.replies.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// ----- robin_hood_hash_table_unit.f -----
design/rhh_pkg.sv
design/rhh_if.sv
design/rhh_hash.sv
design/rhh_slot_ram.sv
design/robin_hood_hash_table_unit.sv
verif/tb_robin_hood_hash_table_unit.sv
